[src/lfud_pkg.sv]
// Shared constants and types for the length-framed UART deframer.
package lfud_pkg;

    localparam int MAX_FRAME = 64;
    localparam int ADDR_W    = $clog2(MAX_FRAME);
    localparam int LEN_W     = 7;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOOTER_BYTE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_EN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN     = 3'd4;

    localparam logic [LEN_W-1:0] MIN_LEN_RST = 7'd11;
    localparam logic [LEN_W-1:0] MAX_LEN_RST = 7'd64;
    localparam logic [LEN_W-1:0] MAX_FRAME_LEN = 7'(MAX_FRAME);

    // start, length, check, footer, plus one
    localparam logic [8:0] FRAME_OVERHEAD = 9'd5;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] footer_byte;
        logic              check_enable;
        logic [LEN_W-1:0]  min_frame_length;
        logic [LEN_W-1:0]  max_frame_length;
    } cfg_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } wr_req_t;

    typedef struct packed {
        logic             valid;
        logic [LEN_W-1:0] total;
    } emit_req_t;

endpackage

[src/lfud_if.sv]
// Channel interfaces: received bytes, frame bytes and configuration writes.
interface lfud_rx_if;
    logic                     valid;
    logic                     ready;
    logic [lfud_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lfud_out_if;
    logic                        valid;
    logic                        ready;
    logic [lfud_pkg::BYTE_W-1:0] frame_byte;
    logic [lfud_pkg::ADDR_W-1:0] byte_index;
    logic [lfud_pkg::LEN_W-1:0]  frame_length;
    logic                        last_byte;

    modport source (output valid, output frame_byte, output byte_index,
                    output frame_length, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input byte_index,
                    input frame_length, input last_byte, output ready);
endinterface

interface lfud_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lfud_pkg::CFG_IDX_W-1:0] index;
    logic [lfud_pkg::BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/length_framed_uart_deframer_core.sv]
// Top level of the length-framed UART deframer.
// Input: one byte per cycle while a frame is collected (write into the frame buffer).
// Output: an accepted frame of N bytes leaves with one buffer read and then one
//   output-register load per byte; input is held off until the last byte is loaded.
// After the transfer of the frame's final byte, the emitter starts, reads the first byte, then loads it out.
// Reset: registers to defaults, parser hunting, emitter idle; buffer is not cleared.
module length_framed_uart_deframer_core (
    input  logic       clk,
    input  logic       rst_n,
    lfud_rx_if.sink    rx,
    lfud_out_if.source frame,
    lfud_cfg_if.sink   cfg
);
    import lfud_pkg::*;

    cfg_t      cfg_reg;
    wr_req_t   wr;
    emit_req_t emit;
    logic              busy;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;
    logic              accept;

    assign cfg.ready = 1'b1;
    assign rx.ready  = !busy;
    assign accept    = rx.valid && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte       <= '0;
            cfg_reg.footer_byte      <= '0;
            cfg_reg.check_enable     <= 1'b1;
            cfg_reg.min_frame_length <= MIN_LEN_RST;
            cfg_reg.max_frame_length <= MAX_LEN_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_START_BYTE:  cfg_reg.start_byte       <= cfg.data;
                REG_FOOTER_BYTE: cfg_reg.footer_byte      <= cfg.data;
                REG_CHECK_EN:    cfg_reg.check_enable     <= cfg.data[0];
                REG_MIN_LEN:     cfg_reg.min_frame_length <= cfg.data[LEN_W-1:0];
                REG_MAX_LEN:     cfg_reg.max_frame_length <= cfg.data[LEN_W-1:0];
                default:         ;
            endcase
        end
    end

    lfud_rx u_rx (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx.rx_byte),
        .cfg     (cfg_reg),
        .wr      (wr),
        .emit    (emit)
    );

    lfud_ram #(
        .DEPTH (MAX_FRAME),
        .WIDTH (BYTE_W)
    ) u_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    lfud_tx u_tx (
        .clk     (clk),
        .rst_n   (rst_n),
        .emit    (emit),
        .rd_data (rd_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .busy    (busy),
        .frame   (frame)
    );

endmodule

[src/lfud_ram.sv]
// Frame buffer: one write port, one registered read port.
module lfud_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/lfud_rx.sv]
// Frame parser: start hunt, length check, buffer writes and frame checks.
module lfud_rx (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [lfud_pkg::BYTE_W-1:0] rx_byte,
    input  lfud_pkg::cfg_t        cfg,
    output lfud_pkg::wr_req_t     wr,
    output lfud_pkg::emit_req_t   emit
);
    import lfud_pkg::*;

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    logic [1:0]        phase_reg, phase_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [LEN_W-1:0]  total_reg, total_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic [BYTE_W-1:0] prev_reg, prev_next;

    logic [8:0]        total_calc;
    logic [LEN_W-1:0]  limit;
    logic [LEN_W-1:0]  fill_inc;
    logic              frame_ok;

    assign total_calc = {1'b0, rx_byte} + FRAME_OVERHEAD;
    assign limit = (cfg.max_frame_length > MAX_FRAME_LEN) ? MAX_FRAME_LEN
                                                           : cfg.max_frame_length;
    assign fill_inc = fill_reg + 7'd1;
    // xor_reg covers positions 2..total-2, prev_reg holds total-2
    assign frame_ok = (rx_byte == cfg.footer_byte)
                   && (!cfg.check_enable || ((xor_reg ^ prev_reg) == prev_reg))
                   && (total_reg >= cfg.min_frame_length);

    always_comb
    begin
        phase_next = phase_reg;
        fill_next  = fill_reg;
        total_next = total_reg;
        xor_next   = xor_reg;
        prev_next  = prev_reg;
        wr.en      = 1'b0;
        wr.addr    = fill_reg[ADDR_W-1:0];
        wr.data    = rx_byte;
        emit.valid = 1'b0;
        emit.total = total_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    wr.en = 1'b1;
                    if (total_calc > {2'b00, limit})
                    begin
                        phase_next = PH_HUNT;
                        fill_next  = '0;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                        fill_next  = fill_inc;
                        total_next = total_calc[LEN_W-1:0];
                        xor_next   = '0;
                    end
                end
                PH_DATA:
                begin
                    wr.en     = 1'b1;
                    xor_next  = xor_reg ^ rx_byte;
                    prev_next = rx_byte;
                    fill_next = fill_inc;
                    if (fill_inc >= total_reg)
                    begin
                        emit.valid = frame_ok;
                        phase_next = PH_HUNT;
                        fill_next  = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    if (rx_byte == cfg.start_byte)
                    begin
                        wr.en      = 1'b1;
                        wr.addr    = '0;
                        fill_next  = 7'd1;
                        phase_next = PH_LEN;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            fill_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xor_reg  <= xor_next;
        prev_reg <= prev_next;
    end

endmodule

[src/lfud_tx.sv]
// Frame emitter: reads the buffer in order into the output register.
module lfud_tx (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lfud_pkg::emit_req_t         emit,
    input  logic [lfud_pkg::BYTE_W-1:0] rd_data,
    output logic                        rd_en,
    output logic [lfud_pkg::ADDR_W-1:0] rd_addr,
    output logic                        busy,
    lfud_out_if.source                  frame
);
    import lfud_pkg::*;

    logic              busy_reg, busy_next;
    logic [LEN_W-1:0]  total_reg, total_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_idx_reg, pend_idx_next;
    logic              ovalid_reg, ovalid_next;
    logic [BYTE_W-1:0] obyte_reg, obyte_next;
    logic [ADDR_W-1:0] oidx_reg, oidx_next;
    logic [LEN_W-1:0]  olen_reg, olen_next;
    logic              olast_reg, olast_next;

    logic slot_free;
    logic pend_last;

    assign slot_free = !ovalid_reg || frame.ready;
    assign rd_en     = busy_reg && !pend_reg && slot_free && (idx_reg < total_reg);
    assign rd_addr   = idx_reg[ADDR_W-1:0];
    assign pend_last = ({1'b0, pend_idx_reg} + 7'd1) == total_reg;
    assign busy      = busy_reg;

    always_comb
    begin
        busy_next     = busy_reg;
        total_next    = total_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        ovalid_next   = ovalid_reg;
        obyte_next    = obyte_reg;
        oidx_next     = oidx_reg;
        olen_next     = olen_reg;
        olast_next    = olast_reg;

        if (emit.valid)
        begin
            busy_next  = 1'b1;
            total_next = emit.total;
            idx_next   = '0;
        end

        if (pend_reg)
        begin
            ovalid_next = 1'b1;
            obyte_next  = rd_data;
            oidx_next   = pend_idx_reg;
            olen_next   = total_reg;
            olast_next  = pend_last;
            pend_next   = 1'b0;
            if (pend_last)
            begin
                busy_next = 1'b0;
            end
        end
        else if (ovalid_reg && frame.ready)
        begin
            ovalid_next = 1'b0;
        end

        if (rd_en)
        begin
            pend_next     = 1'b1;
            pend_idx_next = idx_reg[ADDR_W-1:0];
            idx_next      = idx_reg + 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            total_reg  <= '0;
            idx_reg    <= '0;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            total_reg  <= total_next;
            idx_reg    <= idx_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        obyte_reg    <= obyte_next;
        oidx_reg     <= oidx_next;
        olen_reg     <= olen_next;
        olast_reg    <= olast_next;
    end

    assign frame.valid        = ovalid_reg;
    assign frame.frame_byte   = obyte_reg;
    assign frame.byte_index   = oidx_reg;
    assign frame.frame_length = olen_reg;
    assign frame.last_byte    = olast_reg;

endmodule

[src/lfud_chk.sv]
// Port-level assertions for the deframer, bound to the top level.
module lfud_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        rx_ready,
    input logic                        frame_valid,
    input logic                        frame_ready,
    input logic [lfud_pkg::BYTE_W-1:0] frame_byte,
    input logic [lfud_pkg::ADDR_W-1:0] byte_index,
    input logic [lfud_pkg::LEN_W-1:0]  frame_length,
    input logic                        last_byte
);
    import lfud_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_ready |=> frame_valid && $stable(frame_byte)
            && $stable(byte_index) && $stable(last_byte))
        else $error("frame transfer changed while stalled");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |-> (last_byte == (({1'b0, byte_index} + 7'd1) == frame_length)))
        else $error("last mark does not match index and length");

    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |-> (frame_length >= 7'd5) && (frame_length <= MAX_FRAME_LEN))
        else $error("frame length out of range");

    a_hold_off: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !last_byte |-> !rx_ready)
        else $error("input taken during frame readout");

endmodule

bind length_framed_uart_deframer_core lfud_chk u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_ready     (rx.ready),
    .frame_valid  (frame.valid),
    .frame_ready  (frame.ready),
    .frame_byte   (frame.frame_byte),
    .byte_index   (frame.byte_index),
    .frame_length (frame.frame_length),
    .last_byte    (frame.last_byte)
);

[sim/length_framed_uart_deframer_checker.sv]
// Checker for the UART deframer: predicts frame transfers from rx and cfg traffic and compares.
`timescale 1ns / 100ps

module length_framed_uart_deframer_checker (
    input  logic clk,
    input  logic rst_n,
    lfud_rx_if   rx,
    lfud_out_if  frame,
    lfud_cfg_if  cfg,
    output int   fail_count,
    output int   pending
);
    import lfud_pkg::*;

    typedef enum logic [1:0] {HUNT, LENGTH, COLLECT} parse_phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic [ADDR_W-1:0] byte_index;
        logic [LEN_W-1:0]  frame_length;
        logic              last_byte;
    } frame_beat_t;

    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] footer_byte;
    logic              check_enable;
    logic [LEN_W-1:0]  min_len;
    logic [LEN_W-1:0]  max_len;

    parse_phase_t      phase;
    int                fill;
    int                frame_total;
    logic [BYTE_W-1:0] frame_mem [MAX_FRAME];
    frame_beat_t       expected_beats [$];

    function void restart_hunt();
        phase       = HUNT;
        fill        = 0;
        frame_total = 0;
    endfunction

    function void store_byte(logic [BYTE_W-1:0] b);
        if (fill < MAX_FRAME)
            frame_mem[fill] = b;
        fill++;
    endfunction

    function automatic bit frame_passes();
        logic [BYTE_W-1:0] x;
        x = '0;
        if (frame_total < 5 || frame_total > MAX_FRAME)
            return 1'b0;
        if (frame_mem[frame_total-1] != footer_byte)
            return 1'b0;
        if (check_enable) begin
            for (int i = 2; i + 2 < frame_total; i++)
                x ^= frame_mem[i];
            if (x != frame_mem[frame_total-2])
                return 1'b0;
        end
        return frame_total >= int'(min_len);
    endfunction

    function void queue_frame();
        frame_beat_t beat;
        for (int k = 0; k < frame_total; k++) begin
            beat.frame_byte   = frame_mem[k];
            beat.byte_index   = ADDR_W'(k);
            beat.frame_length = LEN_W'(frame_total);
            beat.last_byte    = (k + 1 == frame_total);
            expected_beats.push_back(beat);
        end
    endfunction

    function void deframe_rx_byte(logic [BYTE_W-1:0] b);
        int limit;
        case (phase)
            LENGTH: begin
                store_byte(b);
                frame_total = int'(b) + 5;
                limit = (int'(max_len) > MAX_FRAME) ? MAX_FRAME : int'(max_len);
                if (frame_total > limit)
                    restart_hunt();
                else
                    phase = COLLECT;
            end
            COLLECT: begin
                store_byte(b);
                if (fill >= frame_total) begin
                    if (frame_passes())
                        queue_frame();
                    restart_hunt();
                end
            end
            default: begin
                phase = HUNT;
                if (b == start_byte) begin
                    fill = 0;
                    store_byte(b);
                    phase = LENGTH;
                end
            end
        endcase
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
        case (idx)
            REG_START_BYTE:  start_byte   = data;
            REG_FOOTER_BYTE: footer_byte  = data;
            REG_CHECK_EN:    check_enable = data[0];
            REG_MIN_LEN:     min_len      = data[LEN_W-1:0];
            REG_MAX_LEN:     max_len      = data[LEN_W-1:0];
            default: ;
        endcase
    endfunction

    function void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function void check_frame_transfer();
        frame_beat_t want;
        if (expected_beats.size() == 0) begin
            $error("frame transfer with none expected: frame_byte %0d byte_index %0d",
                   frame.frame_byte, frame.byte_index);
            fail_count++;
        end else begin
            want = expected_beats.pop_front();
            check_field("frame_byte", want.frame_byte, frame.frame_byte);
            check_field("byte_index", want.byte_index, frame.byte_index);
            check_field("frame_length", want.frame_length, frame.frame_length);
            check_field("last_byte", want.last_byte, frame.last_byte);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start_byte   = '0;
            footer_byte  = '0;
            check_enable = 1'b1;
            min_len      = MIN_LEN_RST;
            max_len      = MAX_LEN_RST;
            fail_count   = 0;
            restart_hunt();
            expected_beats.delete();
            pending <= 0;
        end else begin
            if (cfg.valid && cfg.ready)
                write_register(cfg.index, cfg.data);
            if (frame.valid && frame.ready)
                check_frame_transfer();
            if (rx.valid && rx.ready)
                deframe_rx_byte(rx.rx_byte);
            pending <= expected_beats.size();
        end
    end

endmodule

[sim/length_framed_uart_deframer_core_tb.sv]
// Testbench top for the UART deframer: clock, reset, byte and register stimulus, verdict.
`timescale 1ns / 100ps

module length_framed_uart_deframer_core_tb;
    import lfud_pkg::*;

    localparam int SETTLE_CYCLES  = 2 * MAX_FRAME + 16;
    localparam int WATCHDOG_LIMIT = 4000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   quiet_cycles;
    int   bytes_sent;
    bit   steady;

    logic [BYTE_W-1:0] cur_start;
    logic [BYTE_W-1:0] cur_footer;
    logic [LEN_W-1:0]  cur_max;

    lfud_rx_if  rx_ch();
    lfud_out_if frame_ch();
    lfud_cfg_if cfg_ch();

    length_framed_uart_deframer_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .frame (frame_ch),
        .cfg   (cfg_ch)
    );

    length_framed_uart_deframer_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx_ch),
        .frame      (frame_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #4 clk = ~clk;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            frame_ch.ready <= 1'b0;
        else
            frame_ch.ready <= steady || ($urandom_range(99) >= 37);
    end

    // cycles since the last transfer on any channel
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((rx_ch.valid && rx_ch.ready) || (frame_ch.valid && frame_ch.ready)
                 || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (!steady && $urandom_range(99) < 37) begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic drain(input bit settle);
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_START_BYTE:  cur_start  = data;
            REG_FOOTER_BYTE: cur_footer = data;
            REG_MAX_LEN:     cur_max    = data[LEN_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [BYTE_W-1:0] start_val,
                                  input logic [BYTE_W-1:0] footer_val,
                                  input logic              check_val,
                                  input logic [BYTE_W-1:0] min_val,
                                  input logic [BYTE_W-1:0] max_val);
        drain(1'b1);
        write_reg(REG_START_BYTE, start_val);
        write_reg(REG_FOOTER_BYTE, footer_val);
        write_reg(REG_CHECK_EN, {7'd0, check_val});
        write_reg(REG_MIN_LEN, min_val);
        write_reg(REG_MAX_LEN, max_val);
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] len_field, input bit bad_check,
                              input bit bad_footer);
        logic [BYTE_W-1:0] chk;
        logic [BYTE_W-1:0] d;
        chk = '0;
        send_byte(cur_start);
        send_byte(len_field);
        for (int i = 0; i <= int'(len_field); i++) begin
            d = 8'($urandom_range(255));
            chk ^= d;
            send_byte(d);
        end
        if (bad_check)
            chk ^= 8'(1 << $urandom_range(7));
        send_byte(chk);
        send_byte(bad_footer ? cur_footer ^ 8'($urandom_range(255, 1)) : cur_footer);
    endtask

    // mostly well-formed frames; some noise, oversize lengths and corrupted frames
    task automatic random_traffic(input int n);
        int target;
        int limit;
        int hi;
        int roll;
        int len;
        target = bytes_sent + n;
        while (bytes_sent < target) begin
            limit = (int'(cur_max) > MAX_FRAME) ? MAX_FRAME : int'(cur_max);
            hi    = limit - 5;
            roll  = $urandom_range(99);
            if (roll < 8) begin
                repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
            end else if (roll < 14) begin
                send_byte(cur_start);
                send_byte(8'($urandom_range(255, limit - 4)));
            end else begin
                if ($urandom_range(99) < 85)
                    len = $urandom_range(hi < 10 ? hi : 10, 0);
                else
                    len = $urandom_range(hi, 0);
                send_frame(8'(len), roll < 22, roll >= 22 && roll < 28);
            end
        end
    endtask

    initial begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        steady        = 1'b0;
        bytes_sent    = 0;
        cur_start     = '0;
        cur_footer    = '0;
        cur_max       = MAX_LEN_RST;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        frame_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: start and footer 0x00, shortest accepted total 11
        send_frame(8'd6, 1'b0, 1'b0);

        apply_settings(8'hFF, 8'hFF, 1'b1, 8'd5, 8'd64);
        send_frame(8'd0, 1'b0, 1'b0);
        send_byte(8'hFF);
        send_byte(8'hFF);

        // registers rewritten while a frame is half collected
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h77);
        drain(1'b1);
        write_reg(REG_FOOTER_BYTE, 8'h11);
        write_reg(REG_MAX_LEN, 8'd5);
        send_byte(8'h77);
        send_byte(8'h11);

        // length limit below the smallest possible frame
        drain(1'b1);
        write_reg(REG_MAX_LEN, 8'd4);
        send_frame(8'd0, 1'b0, 1'b0);

        apply_settings(8'hA5, 8'h5A, 1'b1, 8'd5, 8'd64);
        random_traffic(4);
        drain(1'b0);
        random_traffic(4);

        apply_settings(8'h00, 8'hFF, 1'b0, 8'd8, 8'd30);
        steady = 1'b1;
        random_traffic(12);
        drain(1'b0);
        steady = 1'b0;

        apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                       1'($urandom_range(1)), 8'($urandom_range(16, 5)),
                       8'($urandom_range(64, 16)));
        random_traffic(4);

        // only the largest frame passes
        apply_settings(8'h3C, 8'hC3, 1'b1, 8'd64, 8'd64);
        send_frame(8'd59, 1'b0, 1'b0);
        send_frame(8'd2, 1'b0, 1'b0);

        drain(1'b1);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[length_framed_uart_deframer_core.f]
src/lfud_pkg.sv
src/lfud_if.sv
src/lfud_ram.sv
src/lfud_rx.sv
src/lfud_tx.sv
src/length_framed_uart_deframer_core.sv
src/lfud_chk.sv
sim/length_framed_uart_deframer_checker.sv
sim/length_framed_uart_deframer_core_tb.sv
